// ----- rtl/hsfr_pkg.sv -----
// Package for the header/sum frame receiver: constants and the result record.
// No dependencies; used by hsfr_frame_ctrl and header_sum_frame_receiver_top.
`default_nettype none
package hsfr_pkg;

	// frame format
	localparam int FRAME_LEN = 32;
	localparam int POS_W     = $clog2(FRAME_LEN);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
	localparam logic [7:0]       HEADER_BYTE = 8'h8A;
	localparam logic [7:0]       ACK_BASE    = 8'h30;

	// result record, buffer_index in the lowest bit
	typedef struct packed {
		logic [7:0] ack_byte;
		logic       ack_valid;
		logic       checksum_ok;
		logic       buffer_index;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage
`default_nettype wire

// ----- rtl/hsfr_frame_ctrl.sv -----
// Frame tracker: header hunt, byte position, running sum, ping-pong buffer select.
// Depends on hsfr_pkg.
`default_nettype none
module hsfr_frame_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,        // consume rx_byte this cycle
	input  wire logic [7:0]       rx_byte,
	output logic                  frame_last,  // the byte on rx_byte closes the frame
	output hsfr_pkg::result_t     result
);

	logic [hsfr_pkg::POS_W-1:0] pos_q;
	logic [7:0]                 sum_q;
	logic                       buf_q;
	logic                       second_q;

	logic hunting;
	logic sum_match;
	logic ack;

	assign hunting    = (pos_q == '0);
	assign frame_last = !hunting && (pos_q >= hsfr_pkg::LAST_POS);

	// result for the closing byte
	assign sum_match = (rx_byte == sum_q);
	assign ack       = sum_match & second_q;

	always_comb begin
		result.buffer_index = buf_q;
		result.checksum_ok  = sum_match;
		result.ack_valid    = ack;
		result.ack_byte     = ack ? (hsfr_pkg::ACK_BASE + {7'b0, buf_q}) : 8'h00;
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= 8'h00;
			buf_q    <= 1'b0;
			second_q <= 1'b0;
		end else if (step) begin
			if (hunting) begin
				if (rx_byte == hsfr_pkg::HEADER_BYTE) begin
					sum_q    <= rx_byte;
					second_q <= 1'b0;
					pos_q    <= hsfr_pkg::POS_W'(1);
				end
			end else if (frame_last) begin
				buf_q <= ~buf_q;
				pos_q <= '0;
			end else begin
				if (pos_q == hsfr_pkg::POS_W'(1)) begin
					second_q <= (rx_byte == hsfr_pkg::HEADER_BYTE);
				end
				sum_q <= sum_q + rx_byte;
				pos_q <= pos_q + hsfr_pkg::POS_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/header_sum_frame_receiver_top.sv -----
// Top level of the header/sum frame receiver: input register, frame tracker, result register.
// Depends on hsfr_pkg and hsfr_frame_ctrl.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  s_axis   | in  | s_tvalid/s_tready  | s_tdata[7:0]  rx_byte
//  m_axis   | out | m_tvalid/m_tready  | m_tdata[15:0] buffer_index, checksum_ok,
//           |     |                    |               ack_valid, ack_byte
//
// One byte per cycle unless the input register stalls; a closing byte goes through the input
// and result registers. The input register feeds the frame tracker, whose update is a single
// 8-bit add and compare. The input register stalls only when a closing byte meets a full
// result register that is not read in the same cycle. Asynchronous reset clears position,
// sum, buffer select and valids; after reset the block hunts for the header.
`default_nettype none
module header_sum_frame_receiver_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,  // [7:0] rx_byte
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [0] buffer_index, [1] checksum_ok, [2] ack_valid, [10:3] ack_byte, rest zero
	output logic [hsfr_pkg::OUT_DATA_W-1:0]        m_tdata
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	hsfr_pkg::result_t out_q;

	logic              frame_last;
	hsfr_pkg::result_t result;
	logic              out_free;
	logic              step;

	// a closing byte needs a free result slot, other bytes never wait
	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && (!frame_last || out_free);
	assign s_tready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	hsfr_frame_ctrl u_frame_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.frame_last (frame_last),
		.result     (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && frame_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && frame_last) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = hsfr_pkg::OUT_DATA_W'(out_q);

endmodule
`default_nettype wire

// ----- dv/header_sum_frame_receiver_top_test.sv -----
// Testbench for header_sum_frame_receiver_top: streams byte sequences with random gaps,
// predicts each frame result and checks it against the master-side stream.
// Depends on hsfr_pkg and the header_sum_frame_receiver_top RTL.
module header_sum_frame_receiver_top_test;
	import hsfr_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_BYTES  = 870;
	localparam int MAX_REPORTS   = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// frame tracker copy: position, running sum, ping-pong select, byte-1 header flag
	logic [POS_W-1:0] frame_pos;
	logic [7:0]       frame_sum;
	logic             fill_buffer;
	logic             second_hdr;

	result_t frame_results[$];
	int      frame_bytes_sent;
	int      mismatches = 0;
	int      cycles = 0;
	bit      gaps_on;

	header_sum_frame_receiver_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("header_sum_frame_receiver_top: mismatch");
			$finish;
		end
	end

	// advance the frame tracker by one accepted byte, queue a result on the closing byte
	task automatic track_frame_byte(input logic [7:0] b);
		result_t r;
		if (frame_pos == '0) begin
			if (b == HEADER_BYTE) begin
				frame_sum  = b;
				second_hdr = 1'b0;
				frame_pos  = POS_W'(1);
				frame_bytes_sent++;
			end
		end else if (frame_pos >= LAST_POS) begin
			r              = '0;
			r.buffer_index = fill_buffer;
			r.checksum_ok  = (b == frame_sum);
			r.ack_valid    = r.checksum_ok & second_hdr;
			r.ack_byte     = r.ack_valid ? ACK_BASE + {7'd0, fill_buffer} : 8'h00;
			frame_results.push_back(r);
			fill_buffer = ~fill_buffer;
			frame_pos   = '0;
			frame_bytes_sent++;
		end else begin
			if (frame_pos == POS_W'(1))
				second_hdr = (b == HEADER_BYTE);
			frame_sum = frame_sum + b;
			frame_pos = frame_pos + POS_W'(1);
			frame_bytes_sent++;
		end
	endtask

	// one slave-side transaction; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		track_frame_byte(b);
		@(negedge clk);
	endtask

	// header, second byte, body, then the checksum byte (correct or corrupted)
	task automatic send_frame(input logic [7:0] second, input logic [7:0] fill,
			input bit rand_body, input bit good_sum);
		logic [7:0] sum;
		logic [7:0] b;
		sum = HEADER_BYTE;
		send_byte(HEADER_BYTE);
		sum = sum + second;
		send_byte(second);
		for (int i = 2; i < FRAME_LEN - 1; i++) begin
			b   = rand_body ? 8'($urandom_range(0, 255)) : fill;
			sum = sum + b;
			send_byte(b);
		end
		b = good_sum ? sum : sum + 8'($urandom_range(1, 255));
		send_byte(b);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("result %s: expected %h, got %h", name, want, got);
		end
	endtask

	// master-side sink with random stalls
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = gaps_on ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	// compare each result transaction with the oldest queued frame result
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[RESULT_W-1:0];
			if (frame_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result with none expected: got %h", m_tdata);
			end else begin
				want = frame_results.pop_front();
				check_field("buffer_index", 16'(want.buffer_index), 16'(got.buffer_index));
				check_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
				check_field("ack_valid", 16'(want.ack_valid), 16'(got.ack_valid));
				check_field("ack_byte", 16'(want.ack_byte), 16'(got.ack_byte));
				check_field("padding", 16'd0, 16'(m_tdata[OUT_DATA_W-1:RESULT_W]));
			end
		end
	end

	// bytes other than the header are dropped while hunting
	task automatic test_hunt_drops();
		gaps_on = 1'b0;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h8B);
		send_byte(8'h0A);
		send_byte(8'h89);
		gaps_on = 1'b1;
	endtask

	// byte 1 is a header and the sum is right: acknowledge on both buffers, sum wraps
	task automatic test_acknowledged_frames();
		send_frame(HEADER_BYTE, 8'h00, 1'b0, 1'b1);
		send_frame(HEADER_BYTE, 8'hFF, 1'b0, 1'b1);
	endtask

	// good sum but byte 1 is not a header
	task automatic test_unacknowledged_frames();
		send_frame(8'h00, 8'h00, 1'b0, 1'b1);
		send_frame(8'hFF, 8'h55, 1'b0, 1'b1);
	endtask

	// corrupted checksum byte, with and without a header in byte 1
	task automatic test_bad_checksum();
		send_frame(HEADER_BYTE, 8'hAA, 1'b0, 1'b0);
		send_frame(8'h01, 8'hFF, 1'b0, 1'b0);
	endtask

	// header bytes within the body are plain data
	task automatic test_header_inside_frame();
		send_frame(HEADER_BYTE, HEADER_BYTE, 1'b0, 1'b1);
	endtask

	// mostly well-formed frames with random content, some noise and stray headers
	task automatic test_random_traffic();
		int         pick;
		int         n;
		logic [7:0] b;
		logic [7:0] second;
		frame_bytes_sent = 0;
		while (frame_bytes_sent < RANDOM_BYTES) begin
			gaps_on = ($urandom_range(0, 4) != 0);
			pick    = $urandom_range(0, 9);
			if (pick < 2) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					b = 8'($urandom_range(0, 255));
					if (b == HEADER_BYTE && $urandom_range(0, 3) != 0)
						b = 8'h00;
					send_byte(b);
				end
			end else begin
				second = $urandom_range(0, 1) ? HEADER_BYTE : 8'($urandom_range(0, 255));
				send_frame(second, 8'h00, 1'b1, $urandom_range(0, 3) != 0);
			end
		end
		gaps_on = 1'b1;
	endtask

	// wait for every queued result, let the pipeline settle, report
	task automatic test_drain_and_report();
		s_tvalid <= 1'b0;
		while (frame_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && frame_results.size() == 0)
			$display("header_sum_frame_receiver_top: match");
		else
			$display("header_sum_frame_receiver_top: mismatch");
		$finish;
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = 8'h00;
		gaps_on     = 1'b1;
		frame_pos   = '0;
		frame_sum   = 8'h00;
		fill_buffer = 1'b0;
		second_hdr  = 1'b0;
		frame_bytes_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_hunt_drops();
		test_acknowledged_frames();
		test_unacknowledged_frames();
		test_bad_checksum();
		test_header_inside_frame();
		test_random_traffic();
		test_drain_and_report();
	end

endmodule
